// File: sv/linked_list_deque_engine_top_macros.svh
// ---------------------------------------------------------------------------
// Linked list deque engine assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef LINKED_LIST_DEQUE_ENGINE_TOP_MACROS_SVH
`define LINKED_LIST_DEQUE_ENGINE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque engine check failed");

// Consequent must hold in the cycle after the antecedent.
`define LDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque engine check failed");

`endif

// File: sv/ldq_pkg.sv
// ---------------------------------------------------------------------------
// Linked list deque package
// Sizes, command and status codes, and the item and memory port types.
// ---------------------------------------------------------------------------
`default_nettype none

package ldq_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int LINK_W     = IDX_W + 1;
    localparam int COUNT_W    = $clog2(POOL_DEPTH + 1);
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    localparam logic [LINK_W-1:0]  LINK_NULL  = LINK_W'(POOL_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(POOL_DEPTH);

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADHND = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WR_A = 4'b0100,
        ST_WR_B = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data_in;
        logic [IDX_W-1:0]  node_handle;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data_out;
        logic [IDX_W-1:0]    node_out;
        logic [COUNT_W-1:0]  count_out;
    } result_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  addr;
        logic              we_data;
        logic              we_prev;
        logic              we_next;
        logic [DATA_W-1:0] data;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
    } ram_wr_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
    } ram_rd_t;

endpackage

`default_nettype wire

// File: sv/ldq_node_ram.sv
// ---------------------------------------------------------------------------
// Linked list deque node memory
// Pool of nodes holding data and both links, one write and one registered
// read per cycle, with per-field write enables. Entries never written read
// back as the reset free chain.
// ---------------------------------------------------------------------------
`default_nettype none

module ldq_node_ram (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ldq_pkg::ram_wr_t          wr,
    input  wire logic [ldq_pkg::IDX_W-1:0] rd_addr,
    output ldq_pkg::ram_rd_t               rd
);

    logic [ldq_pkg::DATA_W-1:0] data_mem [ldq_pkg::POOL_DEPTH];
    logic [ldq_pkg::LINK_W-1:0] prev_mem [ldq_pkg::POOL_DEPTH];
    logic [ldq_pkg::LINK_W-1:0] next_mem [ldq_pkg::POOL_DEPTH];

    logic [ldq_pkg::POOL_DEPTH-1:0] valid_reg;
    logic                           rd_valid_reg;
    logic [ldq_pkg::IDX_W-1:0]      rd_addr_reg;
    logic [ldq_pkg::DATA_W-1:0]     rd_data_reg;
    logic [ldq_pkg::LINK_W-1:0]     rd_prev_reg;
    logic [ldq_pkg::LINK_W-1:0]     rd_next_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we_data)
        begin
            data_mem[wr.addr] <= wr.data;
        end
        if (wr.we_prev)
        begin
            prev_mem[wr.addr] <= wr.prev;
        end
        if (wr.we_next)
        begin
            next_mem[wr.addr] <= wr.next;
        end
        rd_data_reg <= data_mem[rd_addr];
        rd_prev_reg <= prev_mem[rd_addr];
        rd_next_reg <= next_mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // A node gets all of its fields on the push that first allocates it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we_data)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_comb
    begin
        rd.data = rd_data_reg;
        if (rd_valid_reg)
        begin
            rd.prev = rd_prev_reg;
            rd.next = rd_next_reg;
        end
        else
        begin
            rd.prev = ldq_pkg::LINK_NULL;
            rd.next = ldq_pkg::LINK_W'({1'b0, rd_addr_reg} + 1'b1);
        end
    end

endmodule

`default_nettype wire

// File: sv/linked_list_deque_engine_top.sv
// ---------------------------------------------------------------------------
// Linked list deque engine
// Deque kept as a doubly linked list in a pool of nodes with a free list.
// Push front or back, pop front or back, and remove by handle.
// ---------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  command   start, busy               cmd    (ldq_pkg::cmd_item_t)
//  result    done (one-cycle strobe)   result (ldq_pkg::result_item_t)
//
// An item is taken while busy is low; the node memory read for it starts at
// that edge. A push that links to a neighbor node adds a write of that node's link.
// A pop or remove adds a write for each neighbor link that the single memory
// write port must repair. Rejected and unused commands write nothing.
// The result strobe comes in the cycle after the last write; reset empties
// the deque and chains all nodes on the free list.
// ---------------------------------------------------------------------------
`default_nettype none

module linked_list_deque_engine_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire ldq_pkg::cmd_item_t   cmd,
    output logic                      done,
    output ldq_pkg::result_item_t     result
);

    ldq_pkg::state_t state_reg, state_next;

    logic [ldq_pkg::LINK_W-1:0]     head_reg, head_next;
    logic [ldq_pkg::LINK_W-1:0]     tail_reg, tail_next;
    logic [ldq_pkg::LINK_W-1:0]     free_head_reg, free_head_next;
    logic [ldq_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [ldq_pkg::POOL_DEPTH-1:0] alloc_reg, alloc_next;
    logic                           done_reg, done_next;
    logic                           skip_reg, skip_next;
    logic                           wb_pend_reg, wb_pend_next;
    logic [ldq_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [ldq_pkg::CMD_W-1:0]      op_reg, op_next;
    logic [ldq_pkg::DATA_W-1:0]     data_reg, data_next;
    logic [ldq_pkg::IDX_W-1:0]      n_reg, n_next;
    logic [ldq_pkg::LINK_W-1:0]     p_reg, p_next;
    logic [ldq_pkg::LINK_W-1:0]     x_reg, x_next;
    ldq_pkg::result_item_t          result_reg, result_next;

    logic [ldq_pkg::IDX_W-1:0]    dec_n;
    logic                         dec_skip;
    logic [ldq_pkg::STATUS_W-1:0] dec_status;
    logic                         accept;

    ldq_pkg::ram_wr_t ram_wr;
    ldq_pkg::ram_rd_t ram_rd;

    assign busy   = (state_reg != ldq_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    ldq_node_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ram_wr),
        .rd_addr (dec_n),
        .rd      (ram_rd)
    );

    always_comb
    begin
        dec_n      = '0;
        dec_skip   = 1'b0;
        dec_status = ldq_pkg::STAT_OK;
        case (cmd.command)
            ldq_pkg::CMD_PUSH_FRONT, ldq_pkg::CMD_PUSH_BACK:
            begin
                dec_n = free_head_reg[ldq_pkg::IDX_W-1:0];
                if (free_head_reg == ldq_pkg::LINK_NULL)
                begin
                    dec_skip   = 1'b1;
                    dec_status = ldq_pkg::STAT_FULL;
                end
            end
            ldq_pkg::CMD_POP_FRONT:
            begin
                dec_n = head_reg[ldq_pkg::IDX_W-1:0];
                if (head_reg == ldq_pkg::LINK_NULL)
                begin
                    dec_skip   = 1'b1;
                    dec_status = ldq_pkg::STAT_EMPTY;
                end
            end
            ldq_pkg::CMD_POP_BACK:
            begin
                dec_n = tail_reg[ldq_pkg::IDX_W-1:0];
                if (tail_reg == ldq_pkg::LINK_NULL)
                begin
                    dec_skip   = 1'b1;
                    dec_status = ldq_pkg::STAT_EMPTY;
                end
            end
            ldq_pkg::CMD_REMOVE:
            begin
                dec_n = cmd.node_handle;
                if (!alloc_reg[cmd.node_handle])
                begin
                    dec_skip   = 1'b1;
                    dec_status = ldq_pkg::STAT_BADHND;
                end
            end
            default:
            begin
                dec_skip = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        alloc_next     = alloc_reg;
        done_next      = 1'b0;
        skip_next      = skip_reg;
        wb_pend_next   = wb_pend_reg;
        status_next    = status_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        result_next    = result_reg;
        ram_wr         = '0;

        case (state_reg)
            ldq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd.command;
                    data_next   = cmd.data_in;
                    n_next      = dec_n;
                    skip_next   = dec_skip;
                    status_next = dec_status;
                    state_next  = ldq_pkg::ST_EXEC;
                end
            end
            ldq_pkg::ST_EXEC:
            begin
                result_next.status    = status_reg;
                result_next.data_out  = '0;
                result_next.node_out  = '0;
                result_next.count_out = count_reg;
                wb_pend_next          = 1'b0;
                state_next            = ldq_pkg::ST_IDLE;
                if (skip_reg)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    case (op_reg)
                        ldq_pkg::CMD_PUSH_FRONT, ldq_pkg::CMD_PUSH_BACK:
                        begin
                            ram_wr.addr    = n_reg;
                            ram_wr.we_data = 1'b1;
                            ram_wr.we_prev = 1'b1;
                            ram_wr.we_next = 1'b1;
                            ram_wr.data    = data_reg;
                            free_head_next = ram_rd.next;
                            alloc_next[n_reg] = 1'b1;
                            count_next     = count_reg + 1'b1;
                            result_next.node_out  = n_reg;
                            result_next.count_out = count_reg + 1'b1;
                            if (op_reg == ldq_pkg::CMD_PUSH_FRONT)
                            begin
                                ram_wr.prev = ldq_pkg::LINK_NULL;
                                ram_wr.next = head_reg;
                                p_next      = {1'b0, n_reg};
                                x_next      = head_reg;
                                head_next   = {1'b0, n_reg};
                                if (head_reg == ldq_pkg::LINK_NULL)
                                begin
                                    tail_next = {1'b0, n_reg};
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ldq_pkg::ST_WR_B;
                                end
                            end
                            else
                            begin
                                ram_wr.prev = tail_reg;
                                ram_wr.next = ldq_pkg::LINK_NULL;
                                p_next      = tail_reg;
                                x_next      = {1'b0, n_reg};
                                tail_next   = {1'b0, n_reg};
                                if (tail_reg == ldq_pkg::LINK_NULL)
                                begin
                                    head_next = {1'b0, n_reg};
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ldq_pkg::ST_WR_A;
                                end
                            end
                        end
                        default:
                        begin
                            ram_wr.addr    = n_reg;
                            ram_wr.we_prev = 1'b1;
                            ram_wr.we_next = 1'b1;
                            ram_wr.prev    = ldq_pkg::LINK_NULL;
                            ram_wr.next    = free_head_reg;
                            free_head_next = {1'b0, n_reg};
                            alloc_next[n_reg] = 1'b0;
                            count_next     = count_reg - 1'b1;
                            result_next.data_out  = ram_rd.data;
                            result_next.count_out = count_reg - 1'b1;
                            p_next = ram_rd.prev;
                            x_next = ram_rd.next;
                            if (ram_rd.prev == ldq_pkg::LINK_NULL)
                            begin
                                head_next = ram_rd.next;
                            end
                            if (ram_rd.next == ldq_pkg::LINK_NULL)
                            begin
                                tail_next = ram_rd.prev;
                            end
                            if (ram_rd.prev != ldq_pkg::LINK_NULL)
                            begin
                                wb_pend_next = (ram_rd.next != ldq_pkg::LINK_NULL);
                                state_next   = ldq_pkg::ST_WR_A;
                            end
                            else if (ram_rd.next != ldq_pkg::LINK_NULL)
                            begin
                                state_next = ldq_pkg::ST_WR_B;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ldq_pkg::ST_WR_A:
            begin
                ram_wr.addr    = p_reg[ldq_pkg::IDX_W-1:0];
                ram_wr.we_next = 1'b1;
                ram_wr.next    = x_reg;
                if (wb_pend_reg)
                begin
                    state_next = ldq_pkg::ST_WR_B;
                end
                else
                begin
                    state_next = ldq_pkg::ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ldq_pkg::ST_WR_B:
            begin
                ram_wr.addr    = x_reg[ldq_pkg::IDX_W-1:0];
                ram_wr.we_prev = 1'b1;
                ram_wr.prev    = p_reg;
                state_next     = ldq_pkg::ST_IDLE;
                done_next      = 1'b1;
            end
            default:
            begin
                state_next = ldq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ldq_pkg::ST_IDLE;
            head_reg      <= ldq_pkg::LINK_NULL;
            tail_reg      <= ldq_pkg::LINK_NULL;
            free_head_reg <= '0;
            count_reg     <= '0;
            alloc_reg     <= '0;
            done_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            wb_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            alloc_reg     <= alloc_next;
            done_reg      <= done_next;
            skip_reg      <= skip_next;
            wb_pend_reg   <= wb_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        op_reg     <= op_next;
        data_reg   <= data_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        x_reg      <= x_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// File: sv/ldq_checker.sv
// ---------------------------------------------------------------------------
// Linked list deque port checker
// Watches the top level's ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "linked_list_deque_engine_top_macros.svh"

module ldq_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire ldq_pkg::result_item_t result
);

    `LDQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `LDQ_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `LDQ_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `LDQ_ASSERT_SAME(a_full_count, clk, rst_n, done && (result.status == ldq_pkg::STAT_FULL), (result.count_out == ldq_pkg::COUNT_FULL) && (result.node_out == '0))
    `LDQ_ASSERT_SAME(a_count_range, clk, rst_n, done, result.count_out <= ldq_pkg::COUNT_FULL)

endmodule

bind linked_list_deque_engine_top ldq_checker u_ldq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Linked list deque engine testbench
// Drives push, pop, remove and unused commands through the start/busy port.
// A local copy of the node pool predicts every result, and the done strobe is
// checked field by field against it. A directed opening covers empty pops,
// bad handles, every command and unlinking at the head, middle and tail.
// Random traffic then swings between filling and draining the pool, under
// three sender idle profiles.
// ---------------------------------------------------------------------------

module testbench;

    localparam logic [ldq_pkg::CMD_W-1:0] CMD_NOOP_LO = ldq_pkg::CMD_REMOVE + 3'd1;
    localparam logic [ldq_pkg::CMD_W-1:0] CMD_NOOP_HI = {ldq_pkg::CMD_W{1'b1}};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    ldq_pkg::cmd_item_t    cmd = '0;
    logic                  busy;
    logic                  done;
    ldq_pkg::result_item_t result;

    ldq_pkg::cmd_item_t    cmd_backlog[$];
    ldq_pkg::result_item_t results_due[$];
    logic                  took_item = 1'b0;
    int                    sender_gap = 0;

    logic [ldq_pkg::DATA_W-1:0] pool_data [ldq_pkg::POOL_DEPTH];
    logic [ldq_pkg::LINK_W-1:0] link_next [ldq_pkg::POOL_DEPTH];
    logic [ldq_pkg::LINK_W-1:0] link_prev [ldq_pkg::POOL_DEPTH];
    logic                       in_use    [ldq_pkg::POOL_DEPTH];
    logic [ldq_pkg::LINK_W-1:0] front_idx;
    logic [ldq_pkg::LINK_W-1:0] back_idx;
    logic [ldq_pkg::LINK_W-1:0] free_idx;
    int                         live_count;

    int error_count = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_badhnd = 0;
    int n_noop = 0;
    int peak_count = 0;

    linked_list_deque_engine_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [ldq_pkg::DATA_W-1:0] detach_node(
        logic [ldq_pkg::LINK_W-1:0] n);
        logic [ldq_pkg::LINK_W-1:0] p;
        logic [ldq_pkg::LINK_W-1:0] x;
        logic [ldq_pkg::DATA_W-1:0] v;
        p = link_prev[n[ldq_pkg::IDX_W-1:0]];
        x = link_next[n[ldq_pkg::IDX_W-1:0]];
        if (p != ldq_pkg::LINK_NULL)
            link_next[p[ldq_pkg::IDX_W-1:0]] = x;
        else
            front_idx = x;
        if (x != ldq_pkg::LINK_NULL)
            link_prev[x[ldq_pkg::IDX_W-1:0]] = p;
        else
            back_idx = p;
        v = pool_data[n[ldq_pkg::IDX_W-1:0]];
        in_use[n[ldq_pkg::IDX_W-1:0]] = 1'b0;
        link_prev[n[ldq_pkg::IDX_W-1:0]] = ldq_pkg::LINK_NULL;
        link_next[n[ldq_pkg::IDX_W-1:0]] = free_idx;
        free_idx = n;
        live_count--;
        return v;
    endfunction

    function automatic ldq_pkg::result_item_t deque_apply(ldq_pkg::cmd_item_t c);
        ldq_pkg::result_item_t      r;
        logic [ldq_pkg::LINK_W-1:0] n;
        r = '0;
        r.status = ldq_pkg::STAT_OK;
        case (c.command)
            ldq_pkg::CMD_PUSH_FRONT, ldq_pkg::CMD_PUSH_BACK:
            begin
                if (free_idx == ldq_pkg::LINK_NULL)
                    r.status = ldq_pkg::STAT_FULL;
                else
                begin
                    n = free_idx;
                    free_idx = link_next[n[ldq_pkg::IDX_W-1:0]];
                    pool_data[n[ldq_pkg::IDX_W-1:0]] = c.data_in;
                    in_use[n[ldq_pkg::IDX_W-1:0]] = 1'b1;
                    live_count++;
                    if (c.command == ldq_pkg::CMD_PUSH_FRONT)
                    begin
                        link_prev[n[ldq_pkg::IDX_W-1:0]] = ldq_pkg::LINK_NULL;
                        link_next[n[ldq_pkg::IDX_W-1:0]] = front_idx;
                        if (front_idx != ldq_pkg::LINK_NULL)
                            link_prev[front_idx[ldq_pkg::IDX_W-1:0]] = n;
                        else
                            back_idx = n;
                        front_idx = n;
                    end
                    else
                    begin
                        link_next[n[ldq_pkg::IDX_W-1:0]] = ldq_pkg::LINK_NULL;
                        link_prev[n[ldq_pkg::IDX_W-1:0]] = back_idx;
                        if (back_idx != ldq_pkg::LINK_NULL)
                            link_next[back_idx[ldq_pkg::IDX_W-1:0]] = n;
                        else
                            front_idx = n;
                        back_idx = n;
                    end
                    r.node_out = n[ldq_pkg::IDX_W-1:0];
                end
            end
            ldq_pkg::CMD_POP_FRONT, ldq_pkg::CMD_POP_BACK:
            begin
                n = (c.command == ldq_pkg::CMD_POP_FRONT) ? front_idx : back_idx;
                if (n == ldq_pkg::LINK_NULL)
                    r.status = ldq_pkg::STAT_EMPTY;
                else
                    r.data_out = detach_node(n);
            end
            ldq_pkg::CMD_REMOVE:
            begin
                if (!in_use[c.node_handle])
                    r.status = ldq_pkg::STAT_BADHND;
                else
                    r.data_out = detach_node({1'b0, c.node_handle});
            end
            default:
            begin
            end
        endcase
        r.count_out = ldq_pkg::COUNT_W'(live_count);
        return r;
    endfunction

    task automatic report_field(input string name,
                                input logic [ldq_pkg::DATA_W-1:0] want,
                                input logic [ldq_pkg::DATA_W-1:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    // Driver: a new item goes out once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || took_item))
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_gap)
            begin
                cmd <= cmd_backlog.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: checks the result strobe, then records the item taken at this edge.
    always @(posedge clk)
    begin
        ldq_pkg::result_item_t want;
        ldq_pkg::result_item_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got = result;
                if (results_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, got);
                end
                else
                begin
                    want = results_due.pop_front();
                    n_checked++;
                    if (got.status !== want.status)
                        report_field("status", ldq_pkg::DATA_W'(want.status),
                                     ldq_pkg::DATA_W'(got.status));
                    if (got.data_out !== want.data_out)
                        report_field("data_out", want.data_out, got.data_out);
                    if (got.node_out !== want.node_out)
                        report_field("node_out", ldq_pkg::DATA_W'(want.node_out),
                                     ldq_pkg::DATA_W'(got.node_out));
                    if (got.count_out !== want.count_out)
                        report_field("count_out", ldq_pkg::DATA_W'(want.count_out),
                                     ldq_pkg::DATA_W'(got.count_out));
                end
            end
            if (start && !busy)
            begin
                want = deque_apply(cmd);
                results_due.push_back(want);
                n_accepted++;
                if (want.status == ldq_pkg::STAT_FULL)
                    n_full++;
                if (want.status == ldq_pkg::STAT_EMPTY)
                    n_empty++;
                if (want.status == ldq_pkg::STAT_BADHND)
                    n_badhnd++;
                if (cmd.command > ldq_pkg::CMD_REMOVE)
                    n_noop++;
                if (live_count > peak_count)
                    peak_count = live_count;
            end
        end
        took_item <= rst_n && start && !busy;
    end

    task automatic queue_cmd(input logic [ldq_pkg::CMD_W-1:0] op,
                             input logic [ldq_pkg::DATA_W-1:0] value,
                             input logic [ldq_pkg::IDX_W-1:0] handle);
        ldq_pkg::cmd_item_t c;
        c.command = op;
        c.data_in = value;
        c.node_handle = handle;
        cmd_backlog.push_back(c);
    endtask

    task automatic drain;
        while (cmd_backlog.size() != 0 || start || results_due.size() != 0)
            @(posedge clk);
    endtask

    // Random traffic in blocks of 100 commands (unused codes not counted) that fill, drain, then churn the pool.
    task automatic run_phase(input int n_items, input int gap);
        int                 sent;
        int                 push_pct;
        int                 pick;
        int                 live[$];
        ldq_pkg::cmd_item_t c;
        sender_gap = gap;
        sent = 0;
        while (sent < n_items)
        begin
            @(posedge clk);
            if (cmd_backlog.size() == 0)
            begin
                case ((sent / 100) % 3)
                    0: push_pct = 90;
                    1: push_pct = 15;
                    default: push_pct = 55;
                endcase
                c.data_in = $urandom();
                c.node_handle = ldq_pkg::IDX_W'($urandom_range(ldq_pkg::POOL_DEPTH - 1));
                pick = $urandom_range(99);
                if (pick < 3)
                    c.command = ldq_pkg::CMD_W'($urandom_range(CMD_NOOP_HI, CMD_NOOP_LO));
                else if (pick < 18)
                begin
                    c.command = ldq_pkg::CMD_REMOVE;
                    live.delete();
                    for (int i = 0; i < ldq_pkg::POOL_DEPTH; i++)
                        if (in_use[i])
                            live.push_back(i);
                    if (live.size() != 0 && $urandom_range(3) != 0)
                        c.node_handle = ldq_pkg::IDX_W'(live[$urandom_range(live.size() - 1)]);
                end
                else if ($urandom_range(99) < push_pct)
                    c.command = $urandom_range(1) ? ldq_pkg::CMD_PUSH_BACK
                                                  : ldq_pkg::CMD_PUSH_FRONT;
                else
                    c.command = $urandom_range(1) ? ldq_pkg::CMD_POP_BACK
                                                  : ldq_pkg::CMD_POP_FRONT;
                cmd_backlog.push_back(c);
                if (pick >= 3)
                    sent++;
            end
        end
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < ldq_pkg::POOL_DEPTH; i++)
        begin
            pool_data[i] = '0;
            in_use[i] = 1'b0;
            link_next[i] = ldq_pkg::LINK_W'(i + 1);
            link_prev[i] = ldq_pkg::LINK_NULL;
        end
        front_idx = ldq_pkg::LINK_NULL;
        back_idx = ldq_pkg::LINK_NULL;
        free_idx = '0;
        live_count = 0;
        sender_gap = 8;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_cmd(ldq_pkg::CMD_POP_FRONT, 32'hDEAD_BEEF, '0);
        queue_cmd(ldq_pkg::CMD_POP_BACK, '0, '1);
        queue_cmd(ldq_pkg::CMD_REMOVE, '0, '0);
        queue_cmd(ldq_pkg::CMD_REMOVE, '1, '1);
        for (logic [ldq_pkg::CMD_W:0] op = CMD_NOOP_LO; op <= CMD_NOOP_HI; op++)
            queue_cmd(op[ldq_pkg::CMD_W-1:0], '1, '1);
        queue_cmd(ldq_pkg::CMD_PUSH_FRONT, '0, '1);
        queue_cmd(ldq_pkg::CMD_PUSH_BACK, '1, '0);
        queue_cmd(ldq_pkg::CMD_PUSH_FRONT, 32'hA5A5_A5A5, '0);
        queue_cmd(ldq_pkg::CMD_PUSH_BACK, 32'h5A5A_5A5A, '0);
        queue_cmd(ldq_pkg::CMD_REMOVE, '0, 6'd0);
        queue_cmd(ldq_pkg::CMD_REMOVE, '0, 6'd2);
        queue_cmd(ldq_pkg::CMD_REMOVE, '0, 6'd3);
        queue_cmd(ldq_pkg::CMD_PUSH_FRONT, 32'h1234_5678, '0);
        queue_cmd(ldq_pkg::CMD_POP_BACK, '0, '0);
        queue_cmd(ldq_pkg::CMD_POP_FRONT, '0, '0);
        queue_cmd(ldq_pkg::CMD_PUSH_BACK, 32'hC0DE_0001, '0);
        queue_cmd(ldq_pkg::CMD_REMOVE, '0, 6'd3);
        queue_cmd(ldq_pkg::CMD_PUSH_FRONT, 32'h8000_0001, '0);
        queue_cmd(ldq_pkg::CMD_POP_BACK, '0, '0);
        queue_cmd(ldq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFE, '0);
        queue_cmd(ldq_pkg::CMD_POP_FRONT, '0, '0);
        drain();

        run_phase(320, 8);
        run_phase(320, 67);
        run_phase(310, 0);

        repeat (10) @(posedge clk);
        $display("Accepted %0d commands and checked %0d results; %0d unused codes.",
                 n_accepted, n_checked, n_noop);
        $display("Full pushes %0d, empty pops %0d, bad handles %0d, peak fill %0d of %0d.",
                 n_full, n_empty, n_badhnd, peak_count, ldq_pkg::POOL_DEPTH);
        if (error_count == 0 && results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/ldq_pkg.sv
sv/ldq_node_ram.sv
sv/linked_list_deque_engine_top.sv
sv/ldq_checker.sv
sim/testbench.sv
